/* hw/rtl/hftq_pkg.sv */
// Shared types and constants of the heightfield triangle height query unit.
package hftq_pkg;

    localparam int unsigned POS_W   = 24;
    localparam int unsigned HGT_W   = 16;
    localparam int unsigned SIDX_W  = 11;
    localparam int unsigned CFG_W   = 24;
    localparam int unsigned FRAC_W  = 24;
    localparam int unsigned WT_W    = FRAC_W + 1;
    localparam int unsigned PROD_W  = WT_W + 1 + HGT_W;
    localparam int unsigned SUM_W   = PROD_W + 2;
    localparam int unsigned Q_DEPTH = 4;

    localparam logic [WT_W-1:0] FRAC_ONE = WT_W'(1) << FRAC_W;
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP = 2'd2;

    localparam logic [CFG_W-1:0] INV_STEP_RESET = 24'd65536;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Classification of one item as it travels from the front to the back.
    typedef struct packed {
        logic query;
        logic wr_en;
        logic oob;
        logic upper;
    } t_ctl;

    // Barycentric weights for the corners read through copies a, b and c.
    typedef struct packed {
        logic [WT_W-1:0] wa;
        logic [WT_W-1:0] wb;
        logic [WT_W-1:0] wc;
    } t_wts;

endpackage

/* hw/rtl/heightfield_triangle_height_query_unit.sv */
// Top level of the heightfield triangle height query unit.
//
// Usage: the input channel carries one item per transfer: a height write
// (kind 0) or a height query (kind 1). A write in range stores a sample and
// gives no result; a query gives exactly one result on the output channel.
// Three configuration registers (origin x, origin z, reciprocal cell size)
// are written through the plain write port while the block is idle.
// A query passes the front registers, queue, grid read, products and the
// result register. Throughput is one item per cycle when nothing stalls;
// three corner heights come from three copies of the grid, each read once.
// A four-entry queue separates the front (offset, scaling, classification)
// from the back (grid read, weighting, rounding). When the receiver stalls,
// the result holds and the back freezes; the front keeps taking items until
// the queue fills, then stalls its input. Reset clears the pipeline, queue
// and origins, sets INV_STEP to 65536; the grid is undefined until written.
module heightfield_triangle_height_query_unit #(
    parameter int unsigned SUBDIV = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [hftq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hftq_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_kind,
    input  logic [hftq_pkg::SIDX_W-1:0]        i_sample_index,
    input  logic signed [hftq_pkg::HGT_W-1:0]  i_height_value,
    input  logic signed [hftq_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [hftq_pkg::POS_W-1:0]  i_pos_z,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [hftq_pkg::HGT_W-1:0]  o_height_out,
    output logic                               o_upper_triangle,
    output logic                               o_out_of_chunk
);

    localparam int unsigned AW = $clog2((SUBDIV + 1) * (SUBDIV + 1));
    localparam int unsigned QW = $bits(hftq_pkg::t_ctl) + $bits(hftq_pkg::t_wts)
                               + 3 * AW + hftq_pkg::HGT_W;

    logic                         q_push, q_pop, q_full, q_empty;
    logic [QW-1:0]                q_din, q_dout;
    hftq_pkg::t_ctl               f_ctl, b_ctl;
    hftq_pkg::t_wts               f_wts, b_wts;
    logic [AW-1:0]                f_addr_a, f_addr_b, f_addr_c;
    logic [AW-1:0]                b_addr_a, b_addr_b, b_addr_c;
    logic [hftq_pkg::HGT_W-1:0]   f_wdata, b_wdata;

    hftq_front #(.SUBDIV(SUBDIV)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_sample_index (i_sample_index),
        .i_height_value (i_height_value),
        .i_pos_x        (i_pos_x),
        .i_pos_z        (i_pos_z),
        .o_push         (q_push),
        .i_q_full       (q_full),
        .o_ctl          (f_ctl),
        .o_wts          (f_wts),
        .o_addr_a       (f_addr_a),
        .o_addr_b       (f_addr_b),
        .o_addr_c       (f_addr_c),
        .o_wdata        (f_wdata)
    );

    assign q_din = {f_ctl, f_wts, f_addr_a, f_addr_b, f_addr_c, f_wdata};

    hftq_queue #(.WIDTH(QW), .DEPTH(hftq_pkg::Q_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_din   (q_din),
        .i_pop   (q_pop),
        .o_dout  (q_dout),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign {b_ctl, b_wts, b_addr_a, b_addr_b, b_addr_c, b_wdata} = q_dout;

    hftq_back #(.SUBDIV(SUBDIV)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .o_pop            (q_pop),
        .i_ctl            (b_ctl),
        .i_wts            (b_wts),
        .i_addr_a         (b_addr_a),
        .i_addr_b         (b_addr_b),
        .i_addr_c         (b_addr_c),
        .i_wdata          (b_wdata),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_height_out     (o_height_out),
        .o_upper_triangle (o_upper_triangle),
        .o_out_of_chunk   (o_out_of_chunk)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_oob_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_chunk) |-> (o_height_out == '0 && !o_upper_triangle))
        else $error("out-of-chunk result carries a height or triangle");

    a_stall_holds_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !q_pop)
        else $error("queue popped while the result is held");

endmodule

/* hw/rtl/hftq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hftq_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1089,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/hftq_queue.sv */
// Short register queue that decouples the classifying front from the back.
module hftq_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4,
    localparam int unsigned PW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_din,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_dout,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [PW:0]      r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_din;
        end
    end

    assign o_dout  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

/* hw/rtl/hftq_front.sv */
// Front part: configuration registers, chunk offset, cell scaling and classification.
module hftq_front #(
    parameter int unsigned SUBDIV = 32,
    localparam int unsigned AW = $clog2((SUBDIV + 1) * (SUBDIV + 1))
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hftq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hftq_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_kind,
    input  logic [hftq_pkg::SIDX_W-1:0]     i_sample_index,
    input  logic signed [hftq_pkg::HGT_W-1:0] i_height_value,
    input  logic signed [hftq_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [hftq_pkg::POS_W-1:0] i_pos_z,
    output logic                            o_push,
    input  logic                            i_q_full,
    output hftq_pkg::t_ctl                  o_ctl,
    output hftq_pkg::t_wts                  o_wts,
    output logic [AW-1:0]                   o_addr_a,
    output logic [AW-1:0]                   o_addr_b,
    output logic [AW-1:0]                   o_addr_c,
    output logic [hftq_pkg::HGT_W-1:0]      o_wdata
);

    localparam int unsigned ROW  = SUBDIV + 1;
    localparam int unsigned GRID = ROW * ROW;
    localparam int unsigned CW   = $clog2(ROW);
    localparam int unsigned DW   = hftq_pkg::POS_W + 1;
    localparam int unsigned UW   = 2 * hftq_pkg::POS_W;
    localparam int unsigned FW   = hftq_pkg::FRAC_W;

    logic [hftq_pkg::CFG_W-1:0] r_origin_x, r_origin_z, r_inv_step;

    logic                          r_f1_valid, r_f1_query;
    logic [hftq_pkg::SIDX_W-1:0]   r_f1_idx;
    logic [hftq_pkg::HGT_W-1:0]    r_f1_hgt;
    logic [DW-1:0]                 r_f1_dx, r_f1_dz;

    logic                          r_f2_valid, r_f2_query;
    logic [hftq_pkg::SIDX_W-1:0]   r_f2_idx;
    logic [hftq_pkg::HGT_W-1:0]    r_f2_hgt;
    logic                          r_f2_negx, r_f2_negz;
    logic [UW-1:0]                 r_f2_ux, r_f2_uz;

    logic                          front_en;
    logic [UW-FW-1:0]              cx, cz;
    logic [FW-1:0]                 fx, fz;
    logic [hftq_pkg::WT_W-1:0]     fsum;
    logic                          upper, oob;
    logic [31:0]                   base, idx32, addr_a32, addr_b32, addr_c32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_z <= '0;
            r_inv_step <= hftq_pkg::INV_STEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hftq_pkg::CFG_ORIGIN_X: r_origin_x <= i_cfg_data;
                hftq_pkg::CFG_ORIGIN_Z: r_origin_z <= i_cfg_data;
                hftq_pkg::CFG_INV_STEP: r_inv_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole front holds while a classified item waits on a full queue.
    assign front_en   = !(r_f2_valid && i_q_full);
    assign o_in_stall = !front_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (front_en) begin
            r_f1_valid <= i_in_valid;
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (front_en) begin
            r_f1_query <= (i_kind == hftq_pkg::KIND_QUERY);
            r_f1_idx   <= i_sample_index;
            r_f1_hgt   <= i_height_value;
            r_f1_dx    <= {i_pos_x[hftq_pkg::POS_W-1], i_pos_x}
                        - {r_origin_x[hftq_pkg::CFG_W-1], r_origin_x};
            r_f1_dz    <= {i_pos_z[hftq_pkg::POS_W-1], i_pos_z}
                        - {r_origin_z[hftq_pkg::CFG_W-1], r_origin_z};

            r_f2_query <= r_f1_query;
            r_f2_idx   <= r_f1_idx;
            r_f2_hgt   <= r_f1_hgt;
            r_f2_negx  <= r_f1_dx[DW-1];
            r_f2_negz  <= r_f1_dz[DW-1];
            r_f2_ux    <= r_f1_dx[DW-2:0] * r_inv_step;
            r_f2_uz    <= r_f1_dz[DW-2:0] * r_inv_step;
        end
    end

    always_comb begin
        cx    = r_f2_ux[UW-1:FW];
        cz    = r_f2_uz[UW-1:FW];
        fx    = r_f2_ux[FW-1:0];
        fz    = r_f2_uz[FW-1:0];
        fsum  = {1'b0, fx} + {1'b0, fz};
        upper = (fsum > hftq_pkg::FRAC_ONE);
        oob   = r_f2_negx || r_f2_negz
             || (cx >= (UW-FW)'(SUBDIV)) || (cz >= (UW-FW)'(SUBDIV));
        base  = 32'(cz[CW-1:0]) * 32'(ROW) + 32'(cx[CW-1:0]);
        addr_b32 = base + 32'd1;
        addr_c32 = base + 32'(ROW);
        idx32 = 32'(r_f2_idx);

        o_ctl.query = r_f2_query;
        o_ctl.wr_en = !r_f2_query && (idx32 < 32'(GRID));
        o_ctl.oob   = oob;
        o_ctl.upper = upper && !oob;

        // Copy a serves the corner that differs by triangle, and the write address.
        if (upper) begin
            o_wts.wa = fsum - hftq_pkg::FRAC_ONE;
            o_wts.wb = hftq_pkg::FRAC_ONE - {1'b0, fz};
            o_wts.wc = hftq_pkg::FRAC_ONE - {1'b0, fx};
            addr_a32 = base + 32'(ROW) + 32'd1;
        end else begin
            o_wts.wa = hftq_pkg::FRAC_ONE - fsum;
            o_wts.wb = {1'b0, fx};
            o_wts.wc = {1'b0, fz};
            addr_a32 = base;
        end
        if (!r_f2_query) begin
            addr_a32 = idx32;
        end
    end

    assign o_push   = r_f2_valid && front_en;
    assign o_addr_a = addr_a32[AW-1:0];
    assign o_addr_b = addr_b32[AW-1:0];
    assign o_addr_c = addr_c32[AW-1:0];
    assign o_wdata  = r_f2_hgt;

endmodule

/* hw/rtl/hftq_back.sv */
// Back part: replicated height store, corner weighting, rounding and result register.
module hftq_back #(
    parameter int unsigned SUBDIV = 32,
    localparam int unsigned AW = $clog2((SUBDIV + 1) * (SUBDIV + 1))
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_empty,
    output logic                               o_pop,
    input  hftq_pkg::t_ctl                     i_ctl,
    input  hftq_pkg::t_wts                     i_wts,
    input  logic [AW-1:0]                      i_addr_a,
    input  logic [AW-1:0]                      i_addr_b,
    input  logic [AW-1:0]                      i_addr_c,
    input  logic [hftq_pkg::HGT_W-1:0]         i_wdata,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [hftq_pkg::HGT_W-1:0]  o_height_out,
    output logic                               o_upper_triangle,
    output logic                               o_out_of_chunk
);

    localparam int unsigned GRID = (SUBDIV + 1) * (SUBDIV + 1);
    localparam int unsigned HW   = hftq_pkg::HGT_W;
    localparam int unsigned PW   = hftq_pkg::PROD_W;
    localparam int unsigned SW   = hftq_pkg::SUM_W;
    localparam int unsigned FW   = hftq_pkg::FRAC_W;
    localparam int unsigned RW   = SW - FW;

    logic             back_en, wr, rd;
    logic [HW-1:0]    h_a, h_b, h_c;

    logic             r_b1_valid;
    hftq_pkg::t_ctl   r_b1_ctl;
    hftq_pkg::t_wts   r_b1_wts;

    logic             r_b2_valid;
    hftq_pkg::t_ctl   r_b2_ctl;
    logic signed [PW-1:0] r_p_a, r_p_b, r_p_c;

    logic             r_out_valid, r_out_upper, r_out_oob;
    logic [HW-1:0]    r_out_height;

    logic [SW-1:0]    sum, rnd;
    logic signed [RW-1:0] h_wide;
    logic [HW-1:0]    h_sat;

    // Every stage of the back moves together unless a result is held by the receiver.
    assign back_en = !(r_out_valid && i_out_stall);
    assign o_pop   = back_en && !i_q_empty;
    assign wr      = o_pop && i_ctl.wr_en;
    assign rd      = o_pop && i_ctl.query;

    // Three copies of the grid give the three corners of a triangle in one read.
    hftq_ram #(.WIDTH(HW), .DEPTH(GRID)) u_ram_a (
        .i_clk(i_clk), .i_we(wr), .i_waddr(i_addr_a), .i_wdata(i_wdata),
        .i_re(rd), .i_raddr(i_addr_a), .o_rdata(h_a)
    );
    hftq_ram #(.WIDTH(HW), .DEPTH(GRID)) u_ram_b (
        .i_clk(i_clk), .i_we(wr), .i_waddr(i_addr_a), .i_wdata(i_wdata),
        .i_re(rd), .i_raddr(i_addr_b), .o_rdata(h_b)
    );
    hftq_ram #(.WIDTH(HW), .DEPTH(GRID)) u_ram_c (
        .i_clk(i_clk), .i_we(wr), .i_waddr(i_addr_a), .i_wdata(i_wdata),
        .i_re(rd), .i_raddr(i_addr_c), .o_rdata(h_c)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (back_en) begin
            r_b1_valid  <= rd;
            r_b2_valid  <= r_b1_valid;
            r_out_valid <= r_b2_valid;
        end
    end

    always_comb begin
        sum = {{(SW-PW){r_p_a[PW-1]}}, r_p_a}
            + {{(SW-PW){r_p_b[PW-1]}}, r_p_b}
            + {{(SW-PW){r_p_c[PW-1]}}, r_p_c};
        rnd    = sum + hftq_pkg::ROUND_HALF;
        h_wide = $signed(rnd[SW-1:FW]);
        if (h_wide > RW'(signed'(32767))) begin
            h_sat = 16'h7FFF;
        end else if (h_wide < RW'(signed'(-32768))) begin
            h_sat = 16'h8000;
        end else begin
            h_sat = h_wide[HW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (back_en) begin
            r_b1_ctl <= i_ctl;
            r_b1_wts <= i_wts;

            r_b2_ctl <= r_b1_ctl;
            r_p_a    <= $signed({1'b0, r_b1_wts.wa}) * $signed(h_a);
            r_p_b    <= $signed({1'b0, r_b1_wts.wb}) * $signed(h_b);
            r_p_c    <= $signed({1'b0, r_b1_wts.wc}) * $signed(h_c);

            r_out_upper  <= r_b2_ctl.upper;
            r_out_oob    <= r_b2_ctl.oob;
            r_out_height <= r_b2_ctl.oob ? '0 : h_sat;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_height_out     = r_out_height;
    assign o_upper_triangle = r_out_upper;
    assign o_out_of_chunk   = r_out_oob;

endmodule

/* tb/heightfield_triangle_height_query_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the heightfield triangle height query unit.
module heightfield_triangle_height_query_unit_tb;

    localparam int     SUBDIV       = 32;
    localparam int     GRID_PTS     = (SUBDIV + 1) * (SUBDIV + 1);
    localparam int     SIDX_MAX     = (1 << hftq_pkg::SIDX_W) - 1;
    localparam longint CELL_ONE     = longint'(1) << hftq_pkg::FRAC_W;
    localparam longint POS_MAX      = 8388607;
    localparam longint POS_MIN      = -8388608;
    localparam int     DRAIN_CYCLES = 16;
    localparam int     HOLD_CYCLES  = 80;
    localparam int     PHASE_ITEMS  = 43;
    localparam int     LIMIT_CYCLES = 400000;

    typedef struct {
        logic                              kind;
        logic [hftq_pkg::SIDX_W-1:0]       sidx;
        logic signed [hftq_pkg::HGT_W-1:0] hval;
        logic signed [hftq_pkg::POS_W-1:0] px;
        logic signed [hftq_pkg::POS_W-1:0] pz;
    } t_hf_item;

    typedef struct {
        logic signed [hftq_pkg::HGT_W-1:0] height;
        logic                              upper;
        logic                              oob;
    } t_height_res;

    logic                               i_clk          = 1'b0;
    logic                               i_rst_n        = 1'b0;
    logic                               i_cfg_we       = 1'b0;
    logic [hftq_pkg::CFG_IDX_W-1:0]     i_cfg_index    = hftq_pkg::CFG_ORIGIN_X;
    logic [hftq_pkg::CFG_W-1:0]         i_cfg_data     = '0;
    logic                               i_in_valid     = 1'b0;
    logic                               o_in_stall;
    logic                               i_kind         = hftq_pkg::KIND_WRITE;
    logic [hftq_pkg::SIDX_W-1:0]        i_sample_index = '0;
    logic signed [hftq_pkg::HGT_W-1:0]  i_height_value = '0;
    logic signed [hftq_pkg::POS_W-1:0]  i_pos_x        = '0;
    logic signed [hftq_pkg::POS_W-1:0]  i_pos_z        = '0;
    logic                               o_out_valid;
    logic                               i_out_stall    = 1'b0;
    logic signed [hftq_pkg::HGT_W-1:0]  o_height_out;
    logic                               o_upper_triangle;
    logic                               o_out_of_chunk;

    t_hf_item    pending_ops[$];
    t_height_res expected_heights[$];
    shortint     grid_h [0:GRID_PTS-1];
    longint      org_x;
    longint      org_z;
    longint      inv_m;

    logic in_taken  = 1'b0;
    logic idle_en   = 1'b1;
    logic hold_go   = 1'b0;
    logic hold_seen = 1'b0;
    int   src_gap   = 0;
    int   snk_gap   = 0;
    int   hold_cnt  = 0;
    int   err_cnt   = 0;
    int   cycle_cnt = 0;

    heightfield_triangle_height_query_unit #(
        .SUBDIV(SUBDIV)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_sample_index  (i_sample_index),
        .i_height_value  (i_height_value),
        .i_pos_x         (i_pos_x),
        .i_pos_z         (i_pos_z),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_height_out    (o_height_out),
        .o_upper_triangle(o_upper_triangle),
        .o_out_of_chunk  (o_out_of_chunk)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Expected result of one query against the current grid and registers.
    function automatic t_height_res predict_height(input logic signed [hftq_pkg::POS_W-1:0] px,
                                                   input logic signed [hftq_pkg::POS_W-1:0] pz);
        longint      dx, dz, ux, uz, cx, cz, fx, fz, s;
        longint      h00, h10, h01, h11;
        t_height_res r;
        r.height = '0;
        r.upper  = 1'b0;
        r.oob    = 1'b0;
        dx = longint'(px) - org_x;
        dz = longint'(pz) - org_z;
        if (dx < 0 || dz < 0) begin
            r.oob = 1'b1;
            return r;
        end
        ux = dx * inv_m;
        uz = dz * inv_m;
        cx = ux >>> hftq_pkg::FRAC_W;
        cz = uz >>> hftq_pkg::FRAC_W;
        if (cx >= SUBDIV || cz >= SUBDIV) begin
            r.oob = 1'b1;
            return r;
        end
        fx  = ux & (CELL_ONE - 1);
        fz  = uz & (CELL_ONE - 1);
        h00 = grid_h[cz * (SUBDIV + 1) + cx];
        h10 = grid_h[cz * (SUBDIV + 1) + cx + 1];
        h01 = grid_h[(cz + 1) * (SUBDIV + 1) + cx];
        h11 = grid_h[(cz + 1) * (SUBDIV + 1) + cx + 1];
        // On the diagonal both triangles agree, so the lower one is taken.
        if (fx + fz <= CELL_ONE) begin
            s = (CELL_ONE - fx - fz) * h00 + fx * h10 + fz * h01;
        end else begin
            r.upper = 1'b1;
            s = (fx + fz - CELL_ONE) * h11 + (CELL_ONE - fz) * h10 + (CELL_ONE - fx) * h01;
        end
        r.height = 16'((s + (CELL_ONE >>> 1)) >>> hftq_pkg::FRAC_W);
        return r;
    endfunction

    task automatic record_transfer(input logic kind,
                                   input logic [hftq_pkg::SIDX_W-1:0] sidx,
                                   input logic signed [hftq_pkg::HGT_W-1:0] hval,
                                   input logic signed [hftq_pkg::POS_W-1:0] px,
                                   input logic signed [hftq_pkg::POS_W-1:0] pz);
        if (kind == hftq_pkg::KIND_WRITE) begin
            if (sidx < GRID_PTS)
                grid_h[sidx] = hval;
        end else begin
            expected_heights = {expected_heights, predict_height(px, pz)};
        end
    endtask

    task automatic push_write(input int idx, input int val);
        t_hf_item op;
        op.kind = hftq_pkg::KIND_WRITE;
        op.sidx = hftq_pkg::SIDX_W'(idx);
        op.hval = hftq_pkg::HGT_W'(val);
        op.px   = hftq_pkg::POS_W'($urandom);
        op.pz   = hftq_pkg::POS_W'($urandom);
        pending_ops = {pending_ops, op};
    endtask

    task automatic push_query(input longint px, input longint pz);
        t_hf_item op;
        op.kind = hftq_pkg::KIND_QUERY;
        op.sidx = hftq_pkg::SIDX_W'($urandom);
        op.hval = hftq_pkg::HGT_W'($urandom);
        op.px   = hftq_pkg::POS_W'(px);
        op.pz   = hftq_pkg::POS_W'(pz);
        pending_ops = {pending_ops, op};
    endtask

    function automatic longint clip_pos(input longint p);
        return (p > POS_MAX) ? POS_MAX : p;
    endfunction

    task automatic set_reg(input logic [hftq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hftq_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        unique case (idx)
            hftq_pkg::CFG_ORIGIN_X: org_x = longint'($signed(val));
            hftq_pkg::CFG_ORIGIN_Z: org_z = longint'($signed(val));
            hftq_pkg::CFG_INV_STEP: inv_m = longint'(val);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Writes give no result, so a drain wait after the queues empty lets the last one settle.
    task automatic wait_idle();
        while (pending_ops.size() != 0 || i_in_valid || expected_heights.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly in-chunk queries under the current registers, plus rewrites and noise.
    task automatic queue_mix(input int n);
        int     made;
        int     pick;
        longint dmax;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                push_write($urandom_range(GRID_PTS, SIDX_MAX), $urandom);
            end else begin
                made++;
                if (pick < 15) begin
                    push_write($urandom_range(0, GRID_PTS - 1), $urandom);
                end else if (pick < 25) begin
                    push_query(longint'($signed(24'($urandom))),
                               longint'($signed(24'($urandom))));
                end else begin
                    if (inv_m == 0)
                        dmax = CELL_ONE - 1;
                    else
                        dmax = ((longint'(SUBDIV) << hftq_pkg::FRAC_W) - 1) / inv_m;
                    if (dmax > CELL_ONE - 1)
                        dmax = CELL_ONE - 1;
                    push_query(clip_pos(org_x + $urandom_range(0, 32'(dmax))),
                               clip_pos(org_z + $urandom_range(0, 32'(dmax))));
                end
            end
        end
    endtask

    task automatic run_phase(input longint ox, input longint oz, input longint inv);
        set_reg(hftq_pkg::CFG_ORIGIN_X, 24'(ox));
        set_reg(hftq_pkg::CFG_ORIGIN_Z, 24'(oz));
        set_reg(hftq_pkg::CFG_INV_STEP, 24'(inv));
        queue_mix(PHASE_ITEMS);
        wait_idle();
    endtask

    // Sender: a new item goes out once the previous one has been transferred.
    always @(negedge i_clk) begin
        t_hf_item op;
        if (!i_in_valid || in_taken) begin
            if (src_gap != 0) begin
                i_in_valid <= 1'b0;
                src_gap    <= src_gap - 1;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                i_in_valid <= 1'b0;
                src_gap    <= $urandom_range(0, 8);
            end else if (pending_ops.size() != 0) begin
                op = pending_ops.pop_front();
                i_kind         <= op.kind;
                i_sample_index <= op.sidx;
                i_height_value <= op.hval;
                i_pos_x        <= op.px;
                i_pos_z        <= op.pz;
                i_in_valid     <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, and one long hold-off to fill the block.
    always @(negedge i_clk) begin
        if (hold_go && !hold_seen) begin
            hold_seen   <= 1'b1;
            hold_cnt    <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else if (snk_gap != 0) begin
            snk_gap     <= snk_gap - 1;
            i_out_stall <= 1'b1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            snk_gap     <= $urandom_range(0, 8);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall)
            record_transfer(i_kind, i_sample_index, i_height_value, i_pos_x, i_pos_z);
    end

    always @(posedge i_clk) begin
        t_height_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_heights.size() == 0) begin
                $error("height_out: expected no result, actual %0d", o_height_out);
                err_cnt = err_cnt + 1;
            end else begin
                want = expected_heights.pop_front();
                if (o_height_out !== want.height) begin
                    $error("height_out: expected %0d, actual %0d", want.height, o_height_out);
                    err_cnt = err_cnt + 1;
                end
                if (o_upper_triangle !== want.upper) begin
                    $error("upper_triangle: expected %0b, actual %0b",
                           want.upper, o_upper_triangle);
                    err_cnt = err_cnt + 1;
                end
                if (o_out_of_chunk !== want.oob) begin
                    $error("out_of_chunk: expected %0b, actual %0b", want.oob, o_out_of_chunk);
                    err_cnt = err_cnt + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int i;
        org_x = 0;
        org_z = 0;
        inv_m = longint'(hftq_pkg::INV_STEP_RESET);
        for (i = 0; i < GRID_PTS; i++)
            grid_h[i] = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every grid point is loaded before any query can read it.
        for (i = 0; i < GRID_PTS; i++) begin
            push_write(i, $urandom);
            if ($urandom_range(0, 40) == 0)
                push_write($urandom_range(GRID_PTS, SIDX_MAX), $urandom);
        end
        wait_idle();

        // Directed items under the reset registers: one cell is 256 position units.
        push_write(0, 32767);
        push_write(1, -32768);
        push_write(SUBDIV + 1, -32768);
        push_write(SUBDIV + 2, 32767);
        push_write(GRID_PTS - 1, 4660);
        push_write(SIDX_MAX, 32767);
        push_write(GRID_PTS, -1);
        push_query(0, 0);
        push_query(128, 64);
        push_query(192, 192);
        push_query(64, 192);
        push_query(255, 0);
        push_query(-1, 0);
        push_query(0, -1);
        push_query(SUBDIV * 256, 0);
        push_query(SUBDIV * 256 - 1, SUBDIV * 256 - 1);
        push_query(POS_MAX, POS_MAX);
        push_query(POS_MIN, POS_MIN);
        push_query(31 * 256 + 128, 5 * 256 + 16);
        wait_idle();

        // The long receiver hold-off runs while this phase is being offered.
        queue_mix(PHASE_ITEMS);
        hold_go = 1'b1;
        wait_idle();

        run_phase(POS_MIN, POS_MIN, 1);
        run_phase(POS_MAX, POS_MIN, 16777215);
        run_phase(longint'($urandom_range(0, 200000)) - 100000,
                  longint'($urandom_range(0, 200000)) - 100000, 0);
        run_phase(longint'($urandom_range(0, 200000)) - 100000,
                  longint'($urandom_range(0, 200000)) - 100000,
                  $urandom_range(4096, 2000000));
        run_phase(longint'($urandom_range(0, 2000000)) - 1000000,
                  longint'($urandom_range(0, 2000000)) - 1000000,
                  $urandom_range(1, 16777215));
        idle_en = 1'b0;
        run_phase(-3000, 7000, 196608);

        if (err_cnt == 0 && expected_heights.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/hftq_pkg.sv
hw/rtl/hftq_ram.sv
hw/rtl/hftq_queue.sv
hw/rtl/hftq_front.sv
hw/rtl/hftq_back.sv
hw/rtl/heightfield_triangle_height_query_unit.sv
tb/heightfield_triangle_height_query_unit_tb.sv
